// ===== rtl/core/efe_pkg.sv =====
// efe_pkg: shared types and constants of the escaped frame encoder
// used by every module of the block; depends on nothing
package efe_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT  = 2'd2;

    // input operation codes
    localparam logic OP_BEGIN   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_FRAME   = 2'd1;
    localparam logic [1:0] ST_BEGIN_OPEN = 2'd2;
    localparam logic [1:0] ST_OVERSIZE   = 2'd3;

    // symbol kinds passed from front to back
    localparam logic [1:0] K_ERR  = 2'd0;   // error result, no frame byte
    localparam logic [1:0] K_MARK = 2'd1;   // start marker, sent raw
    localparam logic [1:0] K_DATA = 2'd2;   // framed byte, escaped as needed
    localparam logic [1:0] K_END  = 2'd3;   // end marker, sent raw, size judged

    // escape bytes
    localparam logic [7:0] ESC_LEAD  = 8'd61;
    localparam logic [7:0] ESC_OF_60 = 8'd44;
    localparam logic [7:0] ESC_OF_61 = 8'd45;
    localparam logic [7:0] ESC_OF_62 = 8'd46;
    localparam logic [7:0] RAW_60    = 8'd60;
    localparam logic [7:0] RAW_61    = 8'd61;
    localparam logic [7:0] RAW_62    = 8'd62;

    // emitted byte counter
    localparam int COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    // symbol queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // one symbol between the front and the back
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] val;
        logic       last;
        logic [1:0] status;
    } efe_sym_t;

endpackage

// ===== rtl/core/efe_front.sv =====
// efe_front: accepts input transfers, tracks the open frame and the checksum,
// and breaks each item into symbols for the back end; depends on efe_pkg
module efe_front #(
    parameter int LENGTH_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,
    input  logic             s_tuser,
    input  logic [7:0]       sof_mark,
    input  logic [7:0]       eof_mark,
    output efe_pkg::efe_sym_t push_sym,
    output logic             push_valid,
    input  logic             push_ready
);
    import efe_pkg::*;

    localparam int LEN_W = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
    localparam logic [LEN_W-1:0] LEN_ONE = {{(LEN_W-1){1'b0}}, 1'b1};

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_TYPE = 4'd1;
    localparam logic [3:0] PH_SEQ  = 4'd2;
    localparam logic [3:0] PH_L3   = 4'd3;
    localparam logic [3:0] PH_L2   = 4'd4;
    localparam logic [3:0] PH_L1   = 4'd5;
    localparam logic [3:0] PH_L0   = 4'd6;
    localparam logic [3:0] PH_CSUM = 4'd7;
    localparam logic [3:0] PH_END  = 4'd8;

    logic [3:0]       phase_reg, phase_next;
    logic             open_reg, open_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       seq_reg, seq_next;
    logic [LEN_W-1:0] len_reg, len_next;

    logic [LEN_W-1:0] in_len;
    logic [31:0]      len32;
    logic [7:0]       hdr_byte;

    assign in_len = s_tdata[16+LEN_W-1:16];
    assign len32  = {{(32-LEN_W){1'b0}}, len_reg};
    assign s_tready = (phase_reg == PH_IDLE) && push_ready;

    // header byte for the current phase
    always_comb
    begin
        case (phase_reg)
            PH_TYPE: hdr_byte = type_reg;
            PH_SEQ:  hdr_byte = seq_reg;
            PH_L3:   hdr_byte = len32[31:24];
            PH_L2:   hdr_byte = len32[23:16];
            PH_L1:   hdr_byte = len32[15:8];
            PH_L0:   hdr_byte = len32[7:0];
            default: hdr_byte = 8'd0;
        endcase
    end

    // item classification and frame sequencing
    always_comb
    begin
        phase_next  = phase_reg;
        open_next   = open_reg;
        remain_next = remain_reg;
        sum_next    = sum_reg;
        type_next   = type_reg;
        seq_next    = seq_reg;
        len_next    = len_reg;
        push_valid  = 1'b0;
        push_sym    = '{kind: K_ERR, val: 8'd0, last: 1'b0, status: ST_OK};

        case (phase_reg)
            PH_IDLE:
            begin
                if (s_tvalid && push_ready)
                begin
                    push_valid = 1'b1;
                    if (s_tuser == OP_BEGIN)
                    begin
                        if (open_reg)
                        begin
                            push_sym = '{kind: K_ERR, val: 8'd0, last: 1'b1,
                                         status: ST_BEGIN_OPEN};
                        end
                        else
                        begin
                            push_sym = '{kind: K_MARK, val: sof_mark, last: 1'b0,
                                         status: ST_OK};
                            open_next   = 1'b1;
                            sum_next    = 8'd0;
                            type_next   = s_tdata[7:0];
                            seq_next    = s_tdata[15:8];
                            len_next    = in_len;
                            remain_next = in_len;
                            phase_next  = PH_TYPE;
                        end
                    end
                    else
                    begin
                        if (!open_reg)
                        begin
                            push_sym = '{kind: K_ERR, val: 8'd0, last: 1'b1,
                                         status: ST_NO_FRAME};
                        end
                        else
                        begin
                            push_sym = '{kind: K_DATA, val: s_tdata[39:32],
                                         last: (remain_reg != LEN_ONE), status: ST_OK};
                            sum_next    = sum_reg + s_tdata[39:32];
                            remain_next = remain_reg - LEN_ONE;
                            if (remain_reg == LEN_ONE)
                            begin
                                phase_next = PH_CSUM;
                            end
                        end
                    end
                end
            end
            PH_TYPE, PH_SEQ, PH_L3, PH_L2, PH_L1, PH_L0:
            begin
                if (push_ready)
                begin
                    push_valid = 1'b1;
                    sum_next   = sum_reg + hdr_byte;
                    if (phase_reg == PH_L0)
                    begin
                        push_sym = '{kind: K_DATA, val: hdr_byte,
                                     last: (len_reg != '0), status: ST_OK};
                        phase_next = (len_reg == '0) ? PH_CSUM : PH_IDLE;
                    end
                    else
                    begin
                        push_sym = '{kind: K_DATA, val: hdr_byte, last: 1'b0,
                                     status: ST_OK};
                        phase_next = phase_reg + 4'd1;
                    end
                end
            end
            PH_CSUM:
            begin
                if (push_ready)
                begin
                    push_valid = 1'b1;
                    push_sym   = '{kind: K_DATA, val: sum_reg, last: 1'b0, status: ST_OK};
                    phase_next = PH_END;
                end
            end
            PH_END:
            begin
                if (push_ready)
                begin
                    push_valid  = 1'b1;
                    push_sym    = '{kind: K_END, val: eof_mark, last: 1'b1,
                                    status: ST_OK};
                    open_next   = 1'b0;
                    sum_next    = 8'd0;
                    remain_next = '0;
                    phase_next  = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            open_reg   <= 1'b0;
            remain_reg <= '0;
            sum_reg    <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            open_reg   <= open_next;
            remain_reg <= remain_next;
            sum_reg    <= sum_next;
        end
    end

    // header fields of the open frame
    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        seq_reg  <= seq_next;
        len_reg  <= len_next;
    end

endmodule

// ===== rtl/core/efe_fifo.sv =====
// efe_fifo: short symbol queue between the front and the back end
// depends on efe_pkg for the symbol type and the depth
module efe_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  efe_pkg::efe_sym_t push_sym,
    input  logic              push_valid,
    output logic              push_ready,
    output efe_pkg::efe_sym_t pop_sym,
    output logic              pop_valid,
    input  logic              pop_ready
);
    import efe_pkg::*;

    efe_sym_t           mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   fill_reg, fill_next;
    logic               do_push, do_pop;

    assign push_ready = (fill_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_sym    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + (FIFO_AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_sym;
        end
    end

endmodule

// ===== rtl/core/efe_back.sv =====
// efe_back: turns queued symbols into output bytes, escaping framed bytes,
// counting the frame size and judging oversize on the end marker; depends on efe_pkg
module efe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  efe_pkg::efe_sym_t pop_sym,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  logic [15:0]       frame_limit,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic [3:0]        m_tuser,
    output logic              m_tlast
);
    import efe_pkg::*;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         data_reg, data_next;
    logic [3:0]         user_reg, user_next;
    logic               last_reg, last_next;
    logic               pend_reg, pend_next;
    logic [7:0]         pend_code_reg, pend_code_next;
    logic               pend_last_reg, pend_last_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               load;
    logic               is_esc;
    logic [7:0]         esc_code;
    logic [COUNT_W:0]   cnt_sum;
    logic [COUNT_W-1:0] cnt_sat;
    logic [COUNT_W:0]   end_sum;
    logic [COUNT_W-1:0] end_cnt;
    logic [1:0]         end_status;

    assign load      = !out_valid_reg || m_tready;
    assign pop_ready = load && !pend_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    // escape detection on the queued byte
    always_comb
    begin
        is_esc   = 1'b1;
        esc_code = ESC_OF_60;
        case (pop_sym.val)
            RAW_60:  esc_code = ESC_OF_60;
            RAW_61:  esc_code = ESC_OF_61;
            RAW_62:  esc_code = ESC_OF_62;
            default: is_esc = 1'b0;
        endcase
    end

    // saturating frame size counts
    assign cnt_sum = {1'b0, count_reg} + (is_esc ? (COUNT_W+1)'(2) : (COUNT_W+1)'(1));
    assign cnt_sat = (cnt_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : cnt_sum[COUNT_W-1:0];
    assign end_sum = {1'b0, count_reg} + (COUNT_W+1)'(1);
    assign end_cnt = (end_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : end_sum[COUNT_W-1:0];
    assign end_status = (end_cnt > {1'b0, frame_limit}) ? ST_OVERSIZE : ST_OK;

    // output register load
    always_comb
    begin
        out_valid_next = out_valid_reg;
        data_next      = data_reg;
        user_next      = user_reg;
        last_next      = last_reg;
        pend_next      = pend_reg;
        pend_code_next = pend_code_reg;
        pend_last_next = pend_last_reg;
        count_next     = count_reg;

        if (load)
        begin
            if (pend_reg)
            begin
                out_valid_next = 1'b1;
                data_next      = pend_code_reg;
                user_next      = {ST_OK, 1'b0, 1'b1};
                last_next      = pend_last_reg;
                pend_next      = 1'b0;
            end
            else if (pop_valid)
            begin
                out_valid_next = 1'b1;
                case (pop_sym.kind)
                    K_ERR:
                    begin
                        data_next = 8'd0;
                        user_next = {pop_sym.status, 1'b0, 1'b0};
                        last_next = 1'b1;
                    end
                    K_MARK:
                    begin
                        data_next  = pop_sym.val;
                        user_next  = {ST_OK, 1'b0, 1'b1};
                        last_next  = pop_sym.last;
                        count_next = COUNT_W'(1);
                    end
                    K_DATA:
                    begin
                        user_next  = {ST_OK, 1'b0, 1'b1};
                        count_next = cnt_sat;
                        if (is_esc)
                        begin
                            data_next      = ESC_LEAD;
                            last_next      = 1'b0;
                            pend_next      = 1'b1;
                            pend_code_next = esc_code;
                            pend_last_next = pop_sym.last;
                        end
                        else
                        begin
                            data_next = pop_sym.val;
                            last_next = pop_sym.last;
                        end
                    end
                    K_END:
                    begin
                        data_next  = pop_sym.val;
                        user_next  = {end_status, 1'b1, 1'b1};
                        last_next  = 1'b1;
                        count_next = '0;
                    end
                    default:
                    begin
                        out_valid_next = 1'b0;
                    end
                endcase
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        data_reg      <= data_next;
        user_reg      <= user_next;
        last_reg      <= last_next;
        pend_code_reg <= pend_code_next;
        pend_last_reg <= pend_last_next;
    end

endmodule

// ===== rtl/core/escaped_frame_encoder.sv =====
// escaped_frame_encoder: top level of the byte-stuffed frame encoder
// holds the configuration registers and joins front, symbol queue and back end
// depends on efe_pkg, efe_front, efe_fifo, efe_back
//
// A begin transfer (s_tuser 0) opens a frame and yields the start marker, the type
// and sequence bytes, the length as four big-endian bytes and, for a zero length,
// the checksum and end marker too. Each payload transfer (s_tuser 1) yields one
// byte; the last one also yields the checksum and end marker. Framed bytes 60, 61
// and 62 go out as two bytes. Output runs one byte a cycle from the output
// register while m_tready is high; a payload byte gives one or two output bytes,
// and the last one of a frame adds one or two for the checksum and one for the
// end marker. The front sequencer holds the input while it sends the header
// bytes of a begin item and the checksum and end marker of a frame. A four-entry
// symbol queue lets input and output stall on their own; once it is full the
// input waits for the output.
// Oversize is flagged with status 3 on the end marker; out-of-order items give one
// result with byte_valid 0 and status 1 or 2.
module escaped_frame_encoder #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_type[7:0], seq_number[15:8],
                                   // frame_length[31:16], payload_byte[39:32]
    input  logic        s_tuser,   // op[0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic [3:0]  m_tuser,   // byte_valid[0], frame_done[1], status[3:2]
    output logic        m_tlast,   // run_last
    // configuration writes
    input  logic        cfg_we,
    input  logic [efe_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import efe_pkg::*;

    logic [7:0]  sof_mark_reg;
    logic [7:0]  eof_mark_reg;
    logic [15:0] frame_limit_reg;

    efe_sym_t push_sym, pop_sym;
    logic     push_valid, push_ready;
    logic     pop_valid, pop_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sof_mark_reg    <= 8'd62;
            eof_mark_reg    <= 8'd60;
            frame_limit_reg <= 16'd2048;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_START_MARKER: sof_mark_reg    <= cfg_wdata[7:0];
                CFG_END_MARKER:   eof_mark_reg    <= cfg_wdata[7:0];
                CFG_FRAME_LIMIT:  frame_limit_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // classify items and sequence the header
    efe_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .sof_mark   (sof_mark_reg),
        .eof_mark   (eof_mark_reg),
        .push_sym   (push_sym),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // symbol queue
    efe_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_sym   (push_sym),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_sym    (pop_sym),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // escaping and output
    efe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_sym     (pop_sym),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .frame_limit (frame_limit_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== rtl/core/efe_checker.sv =====
// efe_checker: port-level assertions on the escaped frame encoder output
// bound to escaped_frame_encoder; depends on efe_pkg
module efe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);
    import efe_pkg::*;

    // stalled output transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled output transfer changed");

    // end marker closes the run and carries a frame byte
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast && m_tuser[0])
        else $error("end marker without run_last or byte_valid");

    // an error result is a lone zero byte with an ordering status
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && !m_tuser[1] && (m_tdata == 8'd0)
            && ((m_tuser[3:2] == ST_NO_FRAME) || (m_tuser[3:2] == ST_BEGIN_OPEN)))
        else $error("malformed error result");

    // plain frame bytes carry ok status
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] && !m_tuser[1] |-> (m_tuser[3:2] == ST_OK))
        else $error("frame byte with nonzero status");

    // an escape lead is followed by a framed byte in the next transfer
    a_esc_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser[0] && !m_tuser[1] && (m_tdata == ESC_LEAD)
            && !m_tlast ##1 m_tvalid |-> m_tuser[0] && !m_tuser[1])
        else $error("escape lead not followed by frame byte");

endmodule

bind escaped_frame_encoder efe_checker u_efe_checker (.*);
